### design/h2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

    localparam int HUE_W            = 15;
    localparam int HUE_SPAN         = 1 << (HUE_W - 1);
    localparam int CH_W             = 8;
    localparam int CH_MAX           = 255;
    localparam int P_W              = 2 * CH_W;
    localparam int HUE_FRAC_DEF     = 4;
    localparam int DEG_PER_SECTOR   = 60;
    localparam int SECTORS_PER_TURN = 6;

    // chroma divide by 255: reciprocal estimate then one correction
    localparam int M_CH             = (1 << P_W) / CH_MAX;
    localparam int M_CH_W           = $clog2(M_CH + 1);

    // sample divide by 255 * 60 after the fractional hue bits are shifted out
    localparam int DEN_BASE         = CH_MAX * DEG_PER_SECTOR;
    localparam int Y_W              = 22;
    localparam int M_DEN            = (1 << Y_W) / DEN_BASE;
    localparam int M_DEN_W          = $clog2(M_DEN + 1);

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } h2r_sector_t;

    typedef struct packed {
        logic        valid;
        h2r_sector_t sector;
    } h2r_ctl_t;

endpackage

`default_nettype wire

### design/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// result: a transfer accepted at one clock edge shows its result, with done high,
// for one cycle once it has passed through all the register stages
// throughput: one transfer per cycle, busy stays low; seven register stages in a row
// reset: rst_n low clears all valid bits, so done is low until new work arrives
module hsv_to_rgb_converter
    import h2r_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = HUE_FRAC_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [HUE_W-1:0] hue,
    input  wire logic [CH_W-1:0]         saturation,
    input  wire logic [CH_W-1:0]         brightness,
    output logic                         done,
    output logic [CH_W-1:0]              red,
    output logic [CH_W-1:0]              green,
    output logic [CH_W-1:0]              blue
);

    localparam int R_W = $clog2(DEG_PER_SECTOR << HUE_FRACTION_BITS);

    h2r_ctl_t         hue_ctl;
    logic [R_W-1:0]   hue_r;
    logic [P_W-1:0]   hue_p;
    logic [CH_W-1:0]  hue_b;

    h2r_ctl_t         smp_ctl;
    logic [CH_W-1:0]  smp_peak;
    logic [CH_W-1:0]  smp_s0;
    logic [CH_W-1:0]  smp_s1;
    logic [CH_W-1:0]  smp_s2;

    logic             done_reg;
    logic [CH_W-1:0]  red_reg;
    logic [CH_W-1:0]  green_reg;
    logic [CH_W-1:0]  blue_reg;
    logic [CH_W-1:0]  red_next;
    logic [CH_W-1:0]  green_next;
    logic [CH_W-1:0]  blue_next;

    assign busy = 1'b0;

    h2r_hue_reduce #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_hue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .ctl_out    (hue_ctl),
        .r_out      (hue_r),
        .p_out      (hue_p),
        .b_out      (hue_b)
    );

    h2r_sample #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_sample (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (hue_ctl),
        .r_in    (hue_r),
        .p_in    (hue_p),
        .b_in    (hue_b),
        .ctl_out (smp_ctl),
        .peak    (smp_peak),
        .s0      (smp_s0),
        .s1      (smp_s1),
        .s2      (smp_s2)
    );

    // route the three samples by hue sector
    always_comb
    begin
        case (smp_ctl.sector)
            SEC_RY:
            begin
                red_next   = smp_peak;
                green_next = smp_s2;
                blue_next  = smp_s0;
            end
            SEC_YG:
            begin
                red_next   = smp_s1;
                green_next = smp_peak;
                blue_next  = smp_s0;
            end
            SEC_GC:
            begin
                red_next   = smp_s0;
                green_next = smp_peak;
                blue_next  = smp_s2;
            end
            SEC_CB:
            begin
                red_next   = smp_s0;
                green_next = smp_s1;
                blue_next  = smp_peak;
            end
            SEC_BM:
            begin
                red_next   = smp_s2;
                green_next = smp_s0;
                blue_next  = smp_peak;
            end
            default:
            begin
                red_next   = smp_peak;
                green_next = smp_s0;
                blue_next  = smp_s1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= smp_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

### design/h2r_hue_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

module h2r_hue_reduce
    import h2r_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = HUE_FRAC_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic signed [HUE_W-1:0] hue,
    input  wire logic [CH_W-1:0]      saturation,
    input  wire logic [CH_W-1:0]      brightness,
    output h2r_ctl_t                  ctl_out,
    output logic [$clog2(DEG_PER_SECTOR << HUE_FRACTION_BITS)-1:0] r_out,
    output logic [P_W-1:0]            p_out,
    output logic [CH_W-1:0]           b_out
);

    localparam int SECTOR_UNITS = DEG_PER_SECTOR << HUE_FRACTION_BITS;
    localparam int TURN_UNITS   = SECTOR_UNITS * SECTORS_PER_TURN;
    localparam int H_W          = $clog2(TURN_UNITS);
    localparam int R_W          = $clog2(SECTOR_UNITS);
    localparam int TURN_K       = (HUE_SPAN + TURN_UNITS - 1) / TURN_UNITS;
    localparam int U_W          = $clog2(HUE_SPAN + TURN_K * TURN_UNITS);
    localparam int HUE_OFS      = TURN_K * TURN_UNITS - HUE_SPAN;
    localparam int M_TURN       = (1 << U_W) / TURN_UNITS;
    localparam int MT_W         = $clog2(M_TURN + 1);

    // stage a
    logic              va_reg;
    logic [U_W-1:0]    u_reg;
    logic [MT_W-1:0]   qt_reg;
    logic [P_W-1:0]    pa_reg;
    logic [CH_W-1:0]   ba_reg;
    // stage b
    logic              vb_reg;
    logic [H_W-1:0]    hr_reg;
    logic [P_W-1:0]    pb_reg;
    logic [CH_W-1:0]   bb_reg;
    // stage c
    h2r_ctl_t          ctl_reg;
    logic [R_W-1:0]    r_reg;
    logic [P_W-1:0]    pc_reg;
    logic [CH_W-1:0]   bc_reg;

    logic [U_W-1:0]       u_next;
    logic [U_W+MT_W-1:0]  uprod;
    logic [P_W-1:0]       p_next;
    logic [U_W-1:0]       qt_turn;
    logic [U_W-1:0]       rem;
    logic [H_W-1:0]       hr_next;
    logic [2:0]           cnt;
    logic [R_W-1:0]       r_next;

    // offset binary hue plus whole turns keeps the value non-negative
    always_comb
    begin
        u_next = U_W'({~hue[HUE_W-1], hue[HUE_W-2:0]}) + U_W'(HUE_OFS);
        uprod  = (U_W+MT_W)'(u_next) * (U_W+MT_W)'(M_TURN);
        p_next = P_W'(saturation) * P_W'(brightness);
    end

    always_comb
    begin
        qt_turn = U_W'(int'(qt_reg) * TURN_UNITS);
        rem     = u_reg - qt_turn;
        if (rem >= U_W'(TURN_UNITS))
        begin
            hr_next = H_W'(rem - U_W'(TURN_UNITS));
        end
        else
        begin
            hr_next = H_W'(rem);
        end
    end

    always_comb
    begin
        cnt = 3'd0;
        for (int k = 1; k < SECTORS_PER_TURN; k++)
        begin
            if (hr_reg >= H_W'(k * SECTOR_UNITS))
            begin
                cnt = cnt + 3'd1;
            end
        end
        r_next = R_W'(hr_reg - H_W'(int'(cnt) * SECTOR_UNITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            ctl_reg.valid  <= 1'b0;
            ctl_reg.sector <= SEC_RY;
        end
        else
        begin
            va_reg         <= in_valid;
            vb_reg         <= va_reg;
            ctl_reg.valid  <= vb_reg;
            ctl_reg.sector <= h2r_sector_t'(cnt);
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg          <= u_next;
        qt_reg         <= uprod[U_W +: MT_W];
        pa_reg         <= p_next;
        ba_reg         <= brightness;
        hr_reg         <= hr_next;
        pb_reg         <= pa_reg;
        bb_reg         <= ba_reg;
        r_reg          <= r_next;
        pc_reg         <= pb_reg;
        bc_reg         <= bb_reg;
    end

    assign ctl_out = ctl_reg;
    assign r_out   = r_reg;
    assign p_out   = pc_reg;
    assign b_out   = bc_reg;

    a_hr_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
        vb_reg |-> (hr_reg < H_W'(TURN_UNITS)))
        else $error("reduced hue outside one turn");

    a_r_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> (r_reg < R_W'(SECTOR_UNITS)))
        else $error("sector remainder too large");

endmodule

`default_nettype wire

### design/h2r_sample.sv
`timescale 1ns / 1ps
`default_nettype none

module h2r_sample
    import h2r_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = HUE_FRAC_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire h2r_ctl_t    ctl_in,
    input  wire logic [$clog2(DEG_PER_SECTOR << HUE_FRACTION_BITS)-1:0] r_in,
    input  wire logic [P_W-1:0]  p_in,
    input  wire logic [CH_W-1:0] b_in,
    output h2r_ctl_t         ctl_out,
    output logic [CH_W-1:0]  peak,
    output logic [CH_W-1:0]  s0,
    output logic [CH_W-1:0]  s1,
    output logic [CH_W-1:0]  s2
);

    localparam int SECTOR_UNITS = DEG_PER_SECTOR << HUE_FRACTION_BITS;
    localparam int DEN_FULL     = DEN_BASE << HUE_FRACTION_BITS;
    localparam int X_W          = Y_W + HUE_FRACTION_BITS;
    localparam int YP_W         = Y_W + M_DEN_W;
    localparam int VP_W         = P_W + M_CH_W;

    // stage d
    h2r_ctl_t           ctl_d_reg;
    logic [Y_W-1:0]     y1_d_reg;
    logic [Y_W-1:0]     y2_d_reg;
    logic [P_W-1:0]     v0_reg;
    logic [M_CH_W-1:0]  q0_reg;
    logic [CH_W-1:0]    b_d_reg;
    // stage e
    h2r_ctl_t           ctl_e_reg;
    logic [Y_W-1:0]     y1_e_reg;
    logic [Y_W-1:0]     y2_e_reg;
    logic [M_DEN_W-1:0] q1_reg;
    logic [M_DEN_W-1:0] q2_reg;
    logic [CH_W-1:0]    s0_e_reg;
    logic [CH_W-1:0]    b_e_reg;
    // stage f
    h2r_ctl_t           ctl_f_reg;
    logic [CH_W-1:0]    s0_f_reg;
    logic [CH_W-1:0]    s1_reg;
    logic [CH_W-1:0]    s2_reg;
    logic [CH_W-1:0]    b_f_reg;

    logic [X_W-1:0]     x1;
    logic [X_W-1:0]     x2;
    logic [P_W-1:0]     v0;
    logic [VP_W-1:0]    v0prod;
    logic [YP_W-1:0]    y1prod;
    logic [YP_W-1:0]    y2prod;
    logic [P_W-1:0]     rem0;
    logic [M_CH_W-1:0]  c0;
    logic [CH_W-1:0]    s0_next;
    logic [Y_W-1:0]     rem1;
    logic [Y_W-1:0]     rem2;
    logic [M_DEN_W-1:0] c1;
    logic [M_DEN_W-1:0] c2;

    // ceiling of p*r / (255*T), bias added before the exact shift
    always_comb
    begin
        x1     = X_W'(p_in) * X_W'(r_in) + X_W'(DEN_FULL - 1);
        x2     = X_W'(p_in) * (X_W'(SECTOR_UNITS) - X_W'(r_in)) + X_W'(DEN_FULL - 1);
        v0     = p_in + P_W'(CH_MAX - 1);
        v0prod = VP_W'(v0) * VP_W'(M_CH);
    end

    always_comb
    begin
        y1prod = YP_W'(y1_d_reg) * YP_W'(M_DEN);
        y2prod = YP_W'(y2_d_reg) * YP_W'(M_DEN);
        rem0   = v0_reg - P_W'(int'(q0_reg) * CH_MAX);
        c0     = q0_reg + ((rem0 >= P_W'(CH_MAX)) ? M_CH_W'(1) : M_CH_W'(0));
        s0_next = b_d_reg - CH_W'(c0);
    end

    always_comb
    begin
        rem1 = y1_e_reg - Y_W'(int'(q1_reg) * DEN_BASE);
        rem2 = y2_e_reg - Y_W'(int'(q2_reg) * DEN_BASE);
        c1   = q1_reg + ((rem1 >= Y_W'(DEN_BASE)) ? M_DEN_W'(1) : M_DEN_W'(0));
        c2   = q2_reg + ((rem2 >= Y_W'(DEN_BASE)) ? M_DEN_W'(1) : M_DEN_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg.valid  <= 1'b0;
            ctl_e_reg.valid  <= 1'b0;
            ctl_f_reg.valid  <= 1'b0;
            ctl_d_reg.sector <= SEC_RY;
            ctl_e_reg.sector <= SEC_RY;
            ctl_f_reg.sector <= SEC_RY;
        end
        else
        begin
            ctl_d_reg.valid  <= ctl_in.valid;
            ctl_e_reg.valid  <= ctl_d_reg.valid;
            ctl_f_reg.valid  <= ctl_e_reg.valid;
            ctl_d_reg.sector <= ctl_in.sector;
            ctl_e_reg.sector <= ctl_d_reg.sector;
            ctl_f_reg.sector <= ctl_e_reg.sector;
        end
    end

    always_ff @(posedge clk)
    begin
        y1_d_reg         <= Y_W'(x1 >> HUE_FRACTION_BITS);
        y2_d_reg         <= Y_W'(x2 >> HUE_FRACTION_BITS);
        v0_reg           <= v0;
        q0_reg           <= v0prod[P_W +: M_CH_W];
        b_d_reg          <= b_in;

        y1_e_reg         <= y1_d_reg;
        y2_e_reg         <= y2_d_reg;
        q1_reg           <= y1prod[Y_W +: M_DEN_W];
        q2_reg           <= y2prod[Y_W +: M_DEN_W];
        s0_e_reg         <= s0_next;
        b_e_reg          <= b_d_reg;

        s0_f_reg         <= s0_e_reg;
        s1_reg           <= b_e_reg - CH_W'(c1);
        s2_reg           <= b_e_reg - CH_W'(c2);
        b_f_reg          <= b_e_reg;
    end

    assign ctl_out = ctl_f_reg;
    assign peak    = b_f_reg;
    assign s0      = s0_f_reg;
    assign s1      = s1_reg;
    assign s2      = s2_reg;

    a_s1_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_f_reg.valid |-> (s1_reg <= b_f_reg && s2_reg <= b_f_reg))
        else $error("sample exceeds brightness");

    a_s0_le_s1: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_f_reg.valid |-> (s0_f_reg <= s1_reg))
        else $error("floor sample above falling sample");

    a_s0_le_s2: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_f_reg.valid |-> (s0_f_reg <= s2_reg))
        else $error("floor sample above rising sample");

endmodule

`default_nettype wire
